>>> src/dtwr_pkg.sv
// Shared types and constants for the two-way ranging time-of-flight block.
package dtwr_pkg;

    localparam int STAMP_BITS = 32;
    localparam int DEN_BITS = STAMP_BITS + 2;
    localparam int SCALE_BITS = 24;
    localparam int SCALE_FRACTION_BITS = 16;
    localparam int DIV_CELLS = STAMP_BITS;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd307387;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // Word handed from one divider cell to the next.
    typedef struct packed {
        logic                  vld;
        logic                  zero;
        logic                  neg;
        logic                  big;
        logic [DEN_BITS-1:0]   den;
        logic [DEN_BITS-1:0]   rem;
        logic [STAMP_BITS-1:0] low;
        logic [STAMP_BITS-1:0] quot;
    } t_div_word;

endpackage

>>> src/dtwr_front.sv
// Interval, product and numerator stages ahead of the divider row.
module dtwr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [dtwr_pkg::STAMP_BITS-1:0]     i_remote_poll_sent,
    input  logic [dtwr_pkg::STAMP_BITS-1:0]     i_remote_reply_seen,
    input  logic [dtwr_pkg::STAMP_BITS-1:0]     i_remote_final_sent,
    input  logic [dtwr_pkg::STAMP_BITS-1:0]     i_local_poll_seen,
    input  logic [dtwr_pkg::STAMP_BITS-1:0]     i_local_reply_sent,
    input  logic [dtwr_pkg::STAMP_BITS-1:0]     i_local_final_seen,
    output dtwr_pkg::t_div_word                 o_word
);
    logic                              r_a_vld, r_b_vld, r_c_vld;
    logic [dtwr_pkg::STAMP_BITS-1:0]   r_ra, r_rb, r_da, r_db;
    logic [2*dtwr_pkg::STAMP_BITS-1:0] r_p, r_q, r_num;
    logic [dtwr_pkg::DEN_BITS-1:0]     r_den_b, r_den_c;
    logic                              r_neg;
    dtwr_pkg::t_div_word               r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_word  <= '0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_word.vld  <= r_c_vld;
            r_word.zero <= (r_den_c == '0);
            r_word.neg  <= r_neg;
            r_word.den  <= r_den_c;
            // The quotient overflows 32 bits when the upper numerator half reaches den.
            r_word.big  <= ({2'b00, r_num[2*dtwr_pkg::STAMP_BITS-1:dtwr_pkg::STAMP_BITS]}
                            >= r_den_c);
            r_word.rem  <= {2'b00, r_num[2*dtwr_pkg::STAMP_BITS-1:dtwr_pkg::STAMP_BITS]};
            r_word.low  <= r_num[dtwr_pkg::STAMP_BITS-1:0];
            r_word.quot <= '0;
        end
        r_ra <= i_remote_reply_seen - i_remote_poll_sent;
        r_rb <= i_local_final_seen - i_local_reply_sent;
        r_da <= i_remote_final_sent - i_remote_reply_seen;
        r_db <= i_local_reply_sent - i_local_poll_seen;
        r_p <= {32'd0, r_ra} * {32'd0, r_rb};
        r_q <= {32'd0, r_da} * {32'd0, r_db};
        r_den_b <= {2'b00, r_ra} + {2'b00, r_rb} + {2'b00, r_da} + {2'b00, r_db};
        r_den_c <= r_den_b;
        r_neg <= (r_p < r_q);
        r_num <= (r_p < r_q) ? (r_q - r_p) : (r_p - r_q);
    end

    assign o_word = r_word;
endmodule

>>> src/dtwr_div_cell.sv
// One restoring-division cell: takes one numerator bit and yields one quotient bit.
module dtwr_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dtwr_pkg::t_div_word i_word,
    output dtwr_pkg::t_div_word o_word
);
    dtwr_pkg::t_div_word       r_word, n_word;
    logic [dtwr_pkg::DEN_BITS:0] trial;

    always_comb begin
        n_word = i_word;
        trial = {i_word.rem, i_word.low[dtwr_pkg::STAMP_BITS-1]};
        n_word.low = {i_word.low[dtwr_pkg::STAMP_BITS-2:0], 1'b0};
        if (trial >= {1'b0, i_word.den}) begin
            n_word.rem  = dtwr_pkg::DEN_BITS'(trial - {1'b0, i_word.den});
            n_word.quot = {i_word.quot[dtwr_pkg::STAMP_BITS-2:0], 1'b1};
        end else begin
            n_word.rem  = trial[dtwr_pkg::DEN_BITS-1:0];
            n_word.quot = {i_word.quot[dtwr_pkg::STAMP_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
endmodule

>>> src/dtwr_back.sv
// Clamping, distance scaling and result registers behind the divider row.
module dtwr_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dtwr_pkg::t_div_word                   i_word,
    input  logic [dtwr_pkg::SCALE_BITS-1:0]       i_scale,
    output logic                                  o_done,
    output logic signed [31:0]                    o_flight_ticks,
    output logic signed [31:0]                    o_range_mm,
    output logic [1:0]                            o_status
);
    localparam int PROD_BITS = 32 + dtwr_pkg::SCALE_BITS;
    localparam int RMAG_BITS = PROD_BITS + 1 - dtwr_pkg::SCALE_FRACTION_BITS;

    logic        r_e_vld, r_f_vld, r_done;
    logic        r_e_zero, r_f_zero, r_e_neg, r_f_neg, r_e_sat, r_f_sat;
    logic [31:0] r_e_flight, r_f_flight, r_mag;
    logic [PROD_BITS-1:0] r_prod;
    logic        negf, sat_e;
    logic [31:0] mag_c;
    logic [RMAG_BITS-1:0] rmag;
    logic        rneg, rsat;
    logic [31:0] range_c;
    logic signed [31:0] r_flight_o, r_range_o;
    logic [1:0]  r_status_o;

    always_comb begin
        negf = i_word.neg && (i_word.quot != '0 || i_word.big);
        mag_c = i_word.quot;
        sat_e = 1'b0;
        if (negf) begin
            if (i_word.big || i_word.quot > 32'h8000_0000) begin
                mag_c = 32'h8000_0000;
                sat_e = 1'b1;
            end
        end else if (i_word.big || i_word.quot > 32'h7FFF_FFFF) begin
            mag_c = 32'h7FFF_FFFF;
            sat_e = 1'b1;
        end
    end

    always_comb begin
        if (r_f_neg) begin
            rmag = RMAG_BITS'(({1'b0, r_prod}
                   + {{(PROD_BITS+1-dtwr_pkg::SCALE_FRACTION_BITS){1'b0}},
                      {dtwr_pkg::SCALE_FRACTION_BITS{1'b1}}})
                   >> dtwr_pkg::SCALE_FRACTION_BITS);
        end else begin
            rmag = RMAG_BITS'({1'b0, r_prod} >> dtwr_pkg::SCALE_FRACTION_BITS);
        end
        rneg = r_f_neg && (rmag != '0);
        rsat = 1'b0;
        range_c = rmag[31:0];
        if (rneg) begin
            if (rmag > RMAG_BITS'(33'h0_8000_0000)) begin
                range_c = 32'h8000_0000;
                rsat = 1'b1;
            end
        end else if (rmag > RMAG_BITS'(33'h0_7FFF_FFFF)) begin
            range_c = 32'h7FFF_FFFF;
            rsat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_e_vld <= i_word.vld;
            r_f_vld <= r_e_vld;
            r_done  <= r_f_vld;
        end
        r_e_zero   <= i_word.zero;
        r_e_neg    <= negf;
        r_e_sat    <= sat_e;
        r_mag      <= mag_c;
        r_e_flight <= negf ? (32'd0 - mag_c) : mag_c;
        r_f_zero   <= r_e_zero;
        r_f_neg    <= r_e_neg;
        r_f_sat    <= r_e_sat;
        r_f_flight <= r_e_flight;
        r_prod     <= {{dtwr_pkg::SCALE_BITS{1'b0}}, r_mag}
                      * {32'd0, i_scale};
        if (r_f_zero) begin
            r_flight_o <= '0;
            r_range_o  <= '0;
            r_status_o <= dtwr_pkg::ST_ZERO;
        end else begin
            r_flight_o <= r_f_flight;
            r_range_o  <= rneg ? (32'd0 - range_c) : range_c;
            r_status_o <= (r_f_sat || rsat) ? dtwr_pkg::ST_SAT : dtwr_pkg::ST_OK;
        end
    end

    assign o_done         = r_done;
    assign o_flight_ticks = r_flight_o;
    assign o_range_mm     = r_range_o;
    assign o_status       = r_status_o;
endmodule

>>> src/ds_twr_time_of_flight.sv
// Top level of the double-sided two-way ranging time-of-flight block.
//
// A word is the six 32-bit timestamps of one ranging exchange, presented on
// the i_ stamp ports with i_start. The word is taken at a rising edge with
// i_start high and o_busy low; o_busy stays low, so a new word may be taken
// in every cycle and many exchanges are in flight at once.
// Each result appears on o_flight_ticks, o_range_mm and o_status for exactly
// one cycle with o_done high, and results leave in the order the words came
// in. The receiver cannot stall the block, so it must take every result as
// it is shown. The block is built from four front stages (intervals,
// products, numerator, overflow check), a row of 32 divider cells that each
// yield one quotient bit, and three stages for clamping, the distance
// multiply and rounding.
// The user must write the distance scale through i_cfg_we and i_cfg_wdata
// only while no word is in flight; the block does not enforce it. Reset
// clears every valid flag and sets the scale to its default.
module ds_twr_time_of_flight (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [31:0]          i_remote_poll_sent,
    input  logic [31:0]          i_remote_reply_seen,
    input  logic [31:0]          i_remote_final_sent,
    input  logic [31:0]          i_local_poll_seen,
    input  logic [31:0]          i_local_reply_sent,
    input  logic [31:0]          i_local_final_seen,
    input  logic                 i_cfg_we,
    input  logic [23:0]          i_cfg_wdata,
    output logic                 o_done,
    output logic signed [31:0]   o_flight_ticks,
    output logic signed [31:0]   o_range_mm,
    output logic [1:0]           o_status
);
    logic [dtwr_pkg::SCALE_BITS-1:0] r_scale;
    dtwr_pkg::t_div_word             chain [0:dtwr_pkg::DIV_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= dtwr_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    assign o_busy = 1'b0;

    dtwr_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_vld               (i_start),
        .i_remote_poll_sent  (i_remote_poll_sent),
        .i_remote_reply_seen (i_remote_reply_seen),
        .i_remote_final_sent (i_remote_final_sent),
        .i_local_poll_seen   (i_local_poll_seen),
        .i_local_reply_sent  (i_local_reply_sent),
        .i_local_final_seen  (i_local_final_seen),
        .o_word              (chain[0])
    );

    for (genvar g = 0; g < dtwr_pkg::DIV_CELLS; g++) begin : g_cell
        dtwr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (chain[g]),
            .o_word  (chain[g+1])
        );
    end

    dtwr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (chain[dtwr_pkg::DIV_CELLS]),
        .i_scale        (r_scale),
        .o_done         (o_done),
        .o_flight_ticks (o_flight_ticks),
        .o_range_mm     (o_range_mm),
        .o_status       (o_status)
    );
endmodule

>>> dv/ds_twr_time_of_flight_tb.sv
// Self-checking testbench for the two-way ranging time-of-flight block.
module ds_twr_time_of_flight_tb;

    localparam int LATENCY = 39;
    localparam int WATCHDOG_LIMIT = 400;

    typedef struct {
        logic signed [31:0] flight;
        logic signed [31:0] range;
        logic [1:0]         status;
    } t_range_fix;

    // Keeps the expected fixes in order and computes each one from the stamps.
    class range_scoreboard;
        t_range_fix pending[$];
        logic [23:0] scale;
        int mismatches;
        int checked;

        function new();
            scale = dtwr_pkg::SCALE_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function void note_exchange(logic [31:0] s[6]);
            logic [31:0] ra, rb, da, db;
            logic [33:0] den;
            logic [63:0] p, q;
            logic [63:0] num;
            logic [63:0] mag;
            logic [95:0] prod;
            logic [95:0] rmag;
            logic neg, sat;
            t_range_fix f;
            ra = s[1] - s[0];
            rb = s[5] - s[4];
            da = s[2] - s[1];
            db = s[4] - s[3];
            den = {2'b0, ra} + {2'b0, rb} + {2'b0, da} + {2'b0, db};
            sat = 1'b0;
            if (den == 0) begin
                f.flight = 0;
                f.range = 0;
                f.status = dtwr_pkg::ST_ZERO;
            end else begin
                p = ra * rb;
                q = da * db;
                neg = p < q;
                num = neg ? q - p : p - q;
                mag = num / den;
                if (mag == 0) neg = 1'b0;
                if (neg && mag > 64'h8000_0000) begin
                    mag = 64'h8000_0000;
                    sat = 1'b1;
                end else if (!neg && mag > 64'h7fff_ffff) begin
                    mag = 64'h7fff_ffff;
                    sat = 1'b1;
                end
                f.flight = neg ? -mag[31:0] : mag[31:0];
                prod = mag * scale;
                // Negative distances round toward minus infinity.
                if (neg) rmag = (prod + ((96'd1 << dtwr_pkg::SCALE_FRACTION_BITS) - 1))
                    >> dtwr_pkg::SCALE_FRACTION_BITS;
                else rmag = prod >> dtwr_pkg::SCALE_FRACTION_BITS;
                if (neg && rmag > 96'h8000_0000) begin
                    rmag = 96'h8000_0000;
                    sat = 1'b1;
                end else if (!neg && rmag > 96'h7fff_ffff) begin
                    rmag = 96'h7fff_ffff;
                    sat = 1'b1;
                end
                f.range = neg ? -rmag[31:0] : rmag[31:0];
                f.status = sat ? dtwr_pkg::ST_SAT : dtwr_pkg::ST_OK;
            end
            pending.push_back(f);
        endfunction

        function void check_fix(logic signed [31:0] flight, logic signed [31:0] range,
                                logic [1:0] status);
            t_range_fix e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result flight=%0d", flight);
                return;
            end
            e = pending.pop_front();
            if (e.flight !== flight || e.range !== range || e.status !== status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp flight=%0d range=%0d st=%0d, got %0d %0d %0d",
                             e.flight, e.range, e.status, flight, range, status);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_start, i_cfg_we;
    logic [31:0] stamp [6];
    logic [23:0] i_cfg_wdata;
    logic o_busy, o_done;
    logic signed [31:0] o_flight_ticks, o_range_mm;
    logic [1:0] o_status;
    range_scoreboard sb;
    int idle_cycles;
    int sent;
    bit gaps_on;

    ds_twr_time_of_flight DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_remote_poll_sent(stamp[0]), .i_remote_reply_seen(stamp[1]),
        .i_remote_final_sent(stamp[2]), .i_local_poll_seen(stamp[3]),
        .i_local_reply_sent(stamp[4]), .i_local_final_seen(stamp[5]),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_done(o_done),
        .o_flight_ticks(o_flight_ticks), .o_range_mm(o_range_mm), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        for (int i = 0; i < 6; i++) stamp[i] = '0;
    end

    // Results cannot be held off, so every strobe is checked as it appears.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_fix(o_flight_ticks, o_range_mm, o_status);
            if ((i_start && !o_busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    task automatic send_exchange(logic [31:0] s[6]);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        for (int i = 0; i < 6; i++) stamp[i] <= s[i];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_exchange(s);
        sent++;
    endtask

    // Waits until every fix is back, then lets the pipeline drain.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [23:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.scale = value;
    endtask

    // Builds a well-formed exchange from a start time, intervals and a flight time.
    function automatic void make_exchange(output logic [31:0] s[6], input logic [31:0] t0,
                                          input logic [31:0] reply_a, input logic [31:0] reply_b,
                                          input logic [31:0] tof, input logic [31:0] off);
        s[0] = t0;
        s[1] = t0 + 2 * tof + reply_b;
        s[2] = s[1] + reply_a;
        s[3] = off;
        s[4] = off + reply_b;
        s[5] = s[4] + reply_a + tof + tof;
    endfunction

    function automatic logic [31:0] rand_interval();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 255);
            1: return $urandom_range(0, 32'h000f_ffff);
            2: return $urandom();
            default: return 32'hffff_ffff - $urandom_range(0, 255);
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [31:0] s[6];
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                for (int i = 0; i < 6; i++) s[i] = $urandom();
            end else begin
                make_exchange(s, $urandom(), rand_interval(), rand_interval(),
                              $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 5000),
                              $urandom());
            end
            send_exchange(s);
        end
    endtask

    initial begin
        logic [31:0] s[6];
        sb = new();
        sent = 0;
        gaps_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero stamps, all-ones stamps, wrap, saturation, negative flight.
        for (int i = 0; i < 6; i++) s[i] = '0;
        send_exchange(s);
        for (int i = 0; i < 6; i++) s[i] = 32'hffff_ffff;
        send_exchange(s);
        make_exchange(s, 32'hffff_fff0, 1000, 2000, 50, 32'hffff_ff00);
        send_exchange(s);
        make_exchange(s, 0, 0, 0, 32'h7fff_ffff, 0);
        send_exchange(s);
        s = '{32'd0, 32'hffff_ffff, 32'hffff_fffe, 32'd0, 32'd1, 32'd0};
        send_exchange(s);
        s = '{32'd0, 32'd10, 32'hfff0_0000, 32'd0, 32'hfff0_0000, 32'hfff0_000a};
        send_exchange(s);
        s = '{32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0};
        send_exchange(s);
        s = '{32'd5, 32'd5, 32'd5, 32'd7, 32'd7, 32'd7};
        send_exchange(s);
        make_exchange(s, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 3, 32'haaaa_aaaa);
        send_exchange(s);
        make_exchange(s, 0, 1, 1, 100000, 0);
        send_exchange(s);
        drain();

        write_scale(24'hff_ffff);
        make_exchange(s, 12, 40, 70, 32'h4000_0000, 99);
        send_exchange(s);
        s = '{32'd0, 32'd10, 32'hfff0_0000, 32'd0, 32'hfff0_0000, 32'hfff0_000a};
        send_exchange(s);
        random_phase(450);
        drain();

        write_scale(24'd0);
        random_phase(400);
        drain();

        write_scale(24'd1);
        random_phase(400);
        drain();

        write_scale(dtwr_pkg::SCALE_RESET);
        random_phase(300);
        gaps_on = 1'b0;
        random_phase(300);
        drain();

        $display("Sent %0d ranging exchanges over four scale settings including 0 and max.",
                 sent);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
src/dtwr_pkg.sv
src/dtwr_front.sv
src/dtwr_div_cell.sv
src/dtwr_back.sv
src/ds_twr_time_of_flight.sv
dv/ds_twr_time_of_flight_tb.sv
